FILE: hdl/dasp_pkg.sv
// Shared types, codes and constants of the dual axis step pulse generator.
package dasp_pkg;

    localparam int STEP_W   = 31;
    localparam int RATE_W   = 20;
    localparam int HALF_W   = 19;
    localparam int AXIS_W   = 1;

    localparam int DEF_AXES             = 2;
    localparam int DEF_TICKS_PER_SECOND = 1000000;
    localparam int DEF_MIN_HALF_PERIOD  = 10;

    localparam logic [HALF_W-1:0] HALF_MAX   = '1;
    localparam logic [HALF_W-1:0] HALF_RESET = HALF_W'(10);

    typedef enum logic [1:0] {
        ACT_TICK  = 2'd0,
        ACT_MOVE  = 2'd1,
        ACT_SPEED = 2'd2,
        ACT_STOP  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_INVAL = 2'd1,
        ST_STATE = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_DIV,
        S_APPLY,
        S_RESP
    } t_state;

    typedef struct packed {
        t_action             action;
        logic [AXIS_W-1:0]   axis;
        logic [STEP_W-1:0]   step_count;
        logic                direction;
        logic [RATE_W-1:0]   rate_hz;
    } t_in;

    typedef struct packed {
        t_status status;
        logic    step_line_a;
        logic    dir_line_a;
        logic    step_line_b;
        logic    dir_line_b;
        logic    busy_a;
        logic    busy_b;
        logic    done_a;
        logic    done_b;
    } t_out;

    typedef struct packed {
        logic              tick;
        logic              load;
        logic              speed;
        logic              stop;
        logic              dir;
        logic [STEP_W-1:0] steps;
        logic [HALF_W-1:0] half;
    } t_axis_cmd;

    typedef struct packed {
        logic pulse;
        logic dir;
        logic busy;
        logic done;
    } t_axis_stat;

endpackage

FILE: hdl/dasp_div.sv
// Bit-serial restoring divider turning a step rate into a clamped half period.
module dasp_div #(
    parameter int TICKS_PER_SECOND = dasp_pkg::DEF_TICKS_PER_SECOND,
    parameter int MIN_HALF_PERIOD  = dasp_pkg::DEF_MIN_HALF_PERIOD
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [dasp_pkg::RATE_W-1:0]  i_rate_hz,
    output logic                         o_done,
    output logic [dasp_pkg::HALF_W-1:0]  o_half
);
    import dasp_pkg::*;

    localparam int DW   = $clog2(TICKS_PER_SECOND + 1);
    localparam int CNTW = $clog2(DW);
    localparam int VW   = RATE_W + 1;
    localparam int CW   = (DW > HALF_W) ? DW : HALF_W;

    logic [DW-1:0]   r_num, n_num;
    logic [DW-1:0]   r_quo, n_quo;
    logic [VW-1:0]   r_rem, n_rem;
    logic [VW-1:0]   r_dvs, n_dvs;
    logic [CNTW-1:0] r_cnt, n_cnt;
    logic            r_busy, n_busy;
    logic            r_done, n_done;
    logic [VW:0]     w_trial;
    logic [VW:0]     w_diff;
    logic            w_qbit;
    logic [CW-1:0]   w_q;

    // The trial value stays below twice the divisor, so one subtract per bit suffices.
    assign w_trial = {r_rem, r_num[DW-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_qbit  = (w_trial >= {1'b0, r_dvs});

    always_comb begin
        n_num  = r_num;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        n_done = 1'b0;
        if (i_start) begin
            n_num  = DW'(TICKS_PER_SECOND);
            n_quo  = '0;
            n_rem  = '0;
            n_dvs  = {i_rate_hz, 1'b0};
            n_cnt  = CNTW'(DW - 1);
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_num = r_num << 1;
            n_quo = {r_quo[DW-2:0], w_qbit};
            n_rem = w_qbit ? w_diff[VW-1:0] : w_trial[VW-1:0];
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_num <= n_num;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dvs <= n_dvs;
        r_cnt <= n_cnt;
    end

    always_comb begin
        w_q = CW'(r_quo);
        if (w_q < CW'(MIN_HALF_PERIOD)) begin
            o_half = HALF_W'(MIN_HALF_PERIOD);
        end else if (w_q > CW'(HALF_MAX)) begin
            o_half = HALF_MAX;
        end else begin
            o_half = w_q[HALF_W-1:0];
        end
    end

    assign o_done = r_done;

endmodule

FILE: hdl/dasp_axis.sv
// State and tick logic of one step/direction axis.
module dasp_axis (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  dasp_pkg::t_axis_cmd   i_cmd,
    output dasp_pkg::t_axis_stat  o_stat
);
    import dasp_pkg::*;

    logic [STEP_W-1:0] r_steps, n_steps;
    logic              r_pulse, n_pulse;
    logic [HALF_W-1:0] r_half, n_half;
    logic [HALF_W-1:0] r_elapsed, n_elapsed;
    logic              r_dir, n_dir;
    logic              r_done, n_done;
    logic [HALF_W-1:0] w_inc;

    assign w_inc = r_elapsed + 1'b1;

    always_comb begin
        n_steps   = r_steps;
        n_pulse   = r_pulse;
        n_half    = r_half;
        n_elapsed = r_elapsed;
        n_dir     = r_dir;
        n_done    = r_done;
        if (i_cmd.tick && (r_steps != '0)) begin
            if (w_inc < r_half) begin
                n_elapsed = w_inc;
            end else begin
                n_elapsed = '0;
                // A step is used up on the falling edge of the step line.
                if (r_pulse) begin
                    n_pulse = 1'b0;
                    n_steps = r_steps - 1'b1;
                    if (r_steps == STEP_W'(1)) begin
                        n_done = 1'b1;
                    end
                end else begin
                    n_pulse = 1'b1;
                end
            end
        end
        if (i_cmd.load) begin
            n_dir     = i_cmd.dir;
            n_steps   = i_cmd.steps;
            n_pulse   = 1'b0;
            n_half    = i_cmd.half;
            n_elapsed = '0;
            n_done    = 1'b0;
        end
        if (i_cmd.speed) begin
            n_half    = i_cmd.half;
            n_elapsed = '0;
        end
        if (i_cmd.stop) begin
            n_steps = '0;
            n_pulse = 1'b0;
            n_done  = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_steps   <= '0;
            r_pulse   <= 1'b0;
            r_half    <= HALF_RESET;
            r_elapsed <= '0;
            r_dir     <= 1'b0;
            r_done    <= 1'b0;
        end else begin
            r_steps   <= n_steps;
            r_pulse   <= n_pulse;
            r_half    <= n_half;
            r_elapsed <= n_elapsed;
            r_dir     <= n_dir;
            r_done    <= n_done;
        end
    end

    assign o_stat.pulse = r_pulse;
    assign o_stat.dir   = r_dir;
    assign o_stat.busy  = (r_steps != '0);
    assign o_stat.done  = r_done;

endmodule

FILE: hdl/dual_axis_step_pulse_generator_unit.sv
// Move and set speed requests that pass their checks go through the decode, divide, apply and
// response states; the divide state waits on the bit-serial rate divider, one bit a cycle.
// Tick, stop and rejected requests go from decode straight to apply, then to response.
// One request is in flight at a time; the next is taken once the response has been taken.
// Synchronous active-low reset: all axes idle, step and direction lines low, half period ten.
module dual_axis_step_pulse_generator_unit #(
    parameter int AXES             = dasp_pkg::DEF_AXES,
    parameter int TICKS_PER_SECOND = dasp_pkg::DEF_TICKS_PER_SECOND,
    parameter int MIN_HALF_PERIOD  = dasp_pkg::DEF_MIN_HALF_PERIOD
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  dasp_pkg::t_in  i_in_req,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output dasp_pkg::t_out o_out_rsp
);
    import dasp_pkg::*;

    localparam int AXW = (AXES > 1) ? $clog2(AXES) : 1;

    t_state            r_state, n_state;
    t_in               r_req;
    t_status           r_status;
    t_status           w_status;
    logic              w_axis_ok;
    logic [AXW-1:0]    w_idx;
    logic              w_busy_sel;
    logic              w_div_start;
    logic              w_div_done;
    logic              w_apply;
    logic [HALF_W-1:0] w_half;
    logic [AXES-1:0]   w_busy;
    t_axis_cmd         w_cmd  [AXES];
    t_axis_stat        w_stat [AXES];

    assign w_axis_ok  = (32'(r_req.axis) < AXES);
    assign w_idx      = w_axis_ok ? AXW'(r_req.axis) : '0;
    assign w_busy_sel = w_busy[w_idx];

    always_comb begin
        w_status = ST_OK;
        unique case (r_req.action) inside
            ACT_MOVE: begin
                if (!w_axis_ok || (r_req.step_count == '0) || (r_req.rate_hz == '0)) begin
                    w_status = ST_INVAL;
                end else if (w_busy_sel) begin
                    w_status = ST_STATE;
                end
            end
            ACT_SPEED: begin
                if (!w_axis_ok || (r_req.rate_hz == '0)) begin
                    w_status = ST_INVAL;
                end else if (!w_busy_sel) begin
                    w_status = ST_STATE;
                end
            end
            ACT_TICK, ACT_STOP: begin
                w_status = ST_OK;
            end
            default: begin
                w_status = ST_OK;
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_DECODE;
                end
            end
            S_DECODE: begin
                if (w_div_start) begin
                    n_state = S_DIV;
                end else begin
                    n_state = S_APPLY;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state = S_RESP;
            end
            S_RESP: begin
                if (!i_out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Sequencer outputs.
    always_comb begin
        o_in_stall  = (r_state != S_IDLE);
        o_out_valid = (r_state == S_RESP);
        w_apply     = (r_state == S_APPLY);
        w_div_start = (r_state == S_DECODE) && (w_status == ST_OK) &&
                      ((r_req.action == ACT_MOVE) || (r_req.action == ACT_SPEED));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        if ((r_state == S_IDLE) && i_in_valid) begin
            r_req <= i_in_req;
        end
        if (r_state == S_DECODE) begin
            r_status <= w_status;
        end
    end

    dasp_div #(
        .TICKS_PER_SECOND (TICKS_PER_SECOND),
        .MIN_HALF_PERIOD  (MIN_HALF_PERIOD)
    ) u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_rate_hz (r_req.rate_hz),
        .o_done    (w_div_done),
        .o_half    (w_half)
    );

    for (genvar a = 0; a < AXES; a++) begin : g_axis
        logic w_sel;

        // A rejected request leaves every axis untouched; a tick reaches all of them.
        assign w_sel = w_apply && w_axis_ok && (w_idx == AXW'(a));

        always_comb begin
            w_cmd[a].tick  = w_apply && (r_req.action == ACT_TICK);
            w_cmd[a].load  = w_sel && (r_req.action == ACT_MOVE) && (r_status == ST_OK);
            w_cmd[a].speed = w_sel && (r_req.action == ACT_SPEED) && (r_status == ST_OK);
            w_cmd[a].stop  = w_sel && (r_req.action == ACT_STOP);
            w_cmd[a].dir   = r_req.direction;
            w_cmd[a].steps = r_req.step_count;
            w_cmd[a].half  = w_half;
        end

        dasp_axis u_axis (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (w_cmd[a]),
            .o_stat  (w_stat[a])
        );

        assign w_busy[a] = w_stat[a].busy;
    end

    assign o_out_rsp.status      = r_status;
    assign o_out_rsp.step_line_a = w_stat[0].pulse;
    assign o_out_rsp.dir_line_a  = w_stat[0].dir;
    assign o_out_rsp.busy_a      = w_stat[0].busy;
    assign o_out_rsp.done_a      = w_stat[0].done;

    if (AXES > 1) begin : g_axis_b
        assign o_out_rsp.step_line_b = w_stat[1].pulse;
        assign o_out_rsp.dir_line_b  = w_stat[1].dir;
        assign o_out_rsp.busy_b      = w_stat[1].busy;
        assign o_out_rsp.done_b      = w_stat[1].done;
    end else begin : g_no_axis_b
        assign o_out_rsp.step_line_b = 1'b0;
        assign o_out_rsp.dir_line_b  = 1'b0;
        assign o_out_rsp.busy_b      = 1'b0;
        assign o_out_rsp.done_b      = 1'b0;
    end

endmodule

FILE: tb/sv/dasp_step_checker.sv
// Checker for the step pulse generator: predicts every response from the accepted requests and compares.
module dasp_step_checker #(
    parameter int AXES             = dasp_pkg::DEF_AXES,
    parameter int TICKS_PER_SECOND = dasp_pkg::DEF_TICKS_PER_SECOND,
    parameter int MIN_HALF_PERIOD  = dasp_pkg::DEF_MIN_HALF_PERIOD
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  logic           i_in_stall,
    input  dasp_pkg::t_in  i_in_req,
    input  logic           i_out_valid,
    input  logic           i_out_stall,
    input  dasp_pkg::t_out i_out_rsp,
    output int             o_pending,
    output int             o_fails
);
    timeunit 1ns;
    timeprecision 1ps;
    import dasp_pkg::*;

    // Predicted per-axis state; only two axes fit the one-bit axis field.
    logic [STEP_W-1:0] rem_steps [2];
    logic              step_hi   [2];
    logic [HALF_W-1:0] half_per  [2];
    logic [HALF_W-1:0] tick_cnt  [2];
    logic              dir_lvl   [2];
    logic              fin       [2];

    t_out due_rsp [$];

    function automatic logic [HALF_W-1:0] half_of(input logic [RATE_W-1:0] hz);
        longint unsigned p;
        p = 64'(TICKS_PER_SECOND) / (64'(hz) * 64'd2);
        if (p < MIN_HALF_PERIOD) p = MIN_HALF_PERIOD;
        if (p > HALF_MAX) p = HALF_MAX;
        return HALF_W'(p);
    endfunction

    function automatic void tick_axis(input int a);
        if (rem_steps[a] == '0) return;
        tick_cnt[a] = tick_cnt[a] + 1'b1;
        if (tick_cnt[a] < half_per[a]) return;
        tick_cnt[a] = '0;
        if (step_hi[a]) begin
            // A falling edge completes one step.
            step_hi[a]   = 1'b0;
            rem_steps[a] = rem_steps[a] - 1'b1;
            if (rem_steps[a] == '0) fin[a] = 1'b1;
        end else begin
            step_hi[a] = 1'b1;
        end
    endfunction

    function automatic t_out step_axes(input t_in r);
        t_out o;
        int   ax;
        int   a;
        o        = '0;
        o.status = ST_OK;
        ax       = int'(r.axis);
        case (r.action)
            ACT_TICK: begin
                for (a = 0; a < AXES && a < 2; a++) tick_axis(a);
            end
            ACT_MOVE: begin
                if (ax >= AXES || r.step_count == '0 || r.rate_hz == '0) begin
                    o.status = ST_INVAL;
                end else if (rem_steps[ax] != '0) begin
                    o.status = ST_STATE;
                end else begin
                    dir_lvl[ax]   = r.direction;
                    rem_steps[ax] = r.step_count;
                    step_hi[ax]   = 1'b0;
                    half_per[ax]  = half_of(r.rate_hz);
                    tick_cnt[ax]  = '0;
                    fin[ax]       = 1'b0;
                end
            end
            ACT_SPEED: begin
                if (ax >= AXES || r.rate_hz == '0) begin
                    o.status = ST_INVAL;
                end else if (rem_steps[ax] == '0) begin
                    o.status = ST_STATE;
                end else begin
                    half_per[ax] = half_of(r.rate_hz);
                    tick_cnt[ax] = '0;
                end
            end
            default: begin
                if (ax < AXES) begin
                    rem_steps[ax] = '0;
                    step_hi[ax]   = 1'b0;
                    fin[ax]       = 1'b0;
                end
            end
        endcase
        o.step_line_a = step_hi[0];
        o.dir_line_a  = dir_lvl[0];
        o.busy_a      = rem_steps[0] != '0;
        o.done_a      = fin[0];
        if (AXES > 1) begin
            o.step_line_b = step_hi[1];
            o.dir_line_b  = dir_lvl[1];
            o.busy_b      = rem_steps[1] != '0;
            o.done_b      = fin[1];
        end
        return o;
    endfunction

    task automatic check_field(input string fname, input int unsigned want, input int unsigned got);
        if (want != got) begin
            o_fails++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, fname, want, got);
        end
    endtask

    initial begin
        o_fails   = 0;
        o_pending = 0;
    end

    always @(posedge i_clk) begin : watch
        t_out want;
        int   a;
        if (!i_rst_n) begin
            for (a = 0; a < 2; a++) begin
                rem_steps[a] = '0;
                step_hi[a]   = 1'b0;
                half_per[a]  = HALF_RESET;
                tick_cnt[a]  = '0;
                dir_lvl[a]   = 1'b0;
                fin[a]       = 1'b0;
            end
            due_rsp.delete();
        end else begin
            // Responses are handled before requests: a request never answers within its own edge.
            if (i_out_valid && !i_out_stall) begin
                if (due_rsp.size() == 0) begin
                    o_fails++;
                    $display("%0t: response with none expected, expected nothing, got %h",
                             $time, i_out_rsp);
                end else begin
                    want = due_rsp.pop_front();
                    check_field("status", want.status, i_out_rsp.status);
                    check_field("step_line_a", want.step_line_a, i_out_rsp.step_line_a);
                    check_field("dir_line_a", want.dir_line_a, i_out_rsp.dir_line_a);
                    check_field("step_line_b", want.step_line_b, i_out_rsp.step_line_b);
                    check_field("dir_line_b", want.dir_line_b, i_out_rsp.dir_line_b);
                    check_field("busy_a", want.busy_a, i_out_rsp.busy_a);
                    check_field("busy_b", want.busy_b, i_out_rsp.busy_b);
                    check_field("done_a", want.done_a, i_out_rsp.done_a);
                    check_field("done_b", want.done_b, i_out_rsp.done_b);
                end
            end
            if (i_in_valid && !i_in_stall) due_rsp.push_back(step_axes(i_in_req));
        end
        o_pending = due_rsp.size();
    end

endmodule

FILE: tb/sv/tb.sv
// Top of the step pulse generator testbench: clock, reset, request and response traffic, verdict.
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import dasp_pkg::*;

    localparam int TARGET_REQS = 850;
    localparam int HOLD_AT_RSP = 600;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 300000;
    localparam logic [STEP_W-1:0] SPIN_STEPS = '1;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    t_in  in_req;
    logic out_valid;
    logic out_stall;
    t_out out_rsp;

    int pending;
    int fails;
    int sent;
    int rsp_taken;
    int cycle_cnt;
    bit quiet;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    dual_axis_step_pulse_generator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_req    (in_req),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_rsp   (out_rsp)
    );

    dasp_step_checker chk (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_req    (in_req),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_rsp   (out_rsp),
        .o_pending   (pending),
        .o_fails     (fails)
    );

    function automatic t_in make_req(input t_action act, input logic ax,
                                     input logic [STEP_W-1:0] n, input logic d,
                                     input logic [RATE_W-1:0] hz);
        t_in r;
        r.action     = act;
        r.axis       = ax;
        r.step_count = n;
        r.direction  = d;
        r.rate_hz    = hz;
        return r;
    endfunction

    function automatic logic [STEP_W-1:0] pick_steps();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return STEP_W'($urandom_range(1, 4));
            2:       return STEP_W'($urandom);
            default: return SPIN_STEPS;
        endcase
    endfunction

    // Fast rates keep the half period near its floor so that short moves can finish within the ticks that follow.
    function automatic logic [RATE_W-1:0] pick_rate(input bit fast_only);
        if (fast_only) return RATE_W'($urandom_range(25000, 1048575));
        case ($urandom_range(0, 4))
            0:       return '0;
            1, 2:    return RATE_W'($urandom_range(0, 1048575));
            default: return RATE_W'($urandom_range(25000, 1048575));
        endcase
    endfunction

    task automatic send_req(input t_in r);
        int gap;
        quiet = (sent >= 250 && sent < 350);
        gap   = quiet ? 0 : $urandom_range(0, 10);
        @(negedge clk);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_req   <= r;
        in_valid <= 1'b1;
        do @(posedge clk); while (in_stall);
        sent++;
    endtask

    task automatic drain_pending();
        @(negedge clk);
        in_valid <= 1'b0;
        wait (pending == 0);
    endtask

    initial begin : watchdog
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("dual_axis_step_pulse_generator_unit verification failed");
        $finish;
    end

    // Response side: a random stall before each response, and one long hold that backs the
    // block up while requests keep coming.
    initial begin : rsp_sink
        int hold;
        out_stall = 1'b0;
        rsp_taken = 0;
        wait (rst_n === 1'b1);
        forever begin
            hold = quiet ? 0 : $urandom_range(0, 10);
            if (rsp_taken == HOLD_AT_RSP) hold = HOLD_CYCLES;
            if (hold > 0) begin
                @(negedge clk);
                out_stall <= 1'b1;
                repeat (hold) @(negedge clk);
                out_stall <= 1'b0;
            end
            do @(posedge clk); while (!(out_valid && !out_stall));
            rsp_taken++;
        end
    end

    initial begin : stimulus
        int  n_ticks;
        int  k;
        bit  drained;
        logic ax;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        in_req   = '0;
        quiet    = 1'b0;
        sent     = 0;
        drained  = 1'b0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: rejections, clamped and slowest rates, a spin, a finished move, stops.
        send_req(make_req(ACT_TICK, 1'b0, '0, 1'b0, '0));
        send_req(make_req(ACT_SPEED, 1'b0, '0, 1'b0, RATE_W'(1000)));
        send_req(make_req(ACT_MOVE, 1'b0, '0, 1'b1, RATE_W'(1000)));
        send_req(make_req(ACT_MOVE, 1'b1, STEP_W'(5), 1'b1, '0));
        send_req(make_req(ACT_SPEED, 1'b1, '0, 1'b0, '0));
        send_req(make_req(ACT_MOVE, 1'b0, STEP_W'(1), 1'b1, '1));
        send_req(make_req(ACT_MOVE, 1'b0, STEP_W'(3), 1'b0, RATE_W'(500)));
        send_req(make_req(ACT_MOVE, 1'b1, SPIN_STEPS, 1'b1, RATE_W'(1)));
        send_req(make_req(ACT_SPEED, 1'b1, '0, 1'b0, RATE_W'(1000000)));
        // Twenty ticks at the minimum half period finish the single step on axis 0.
        repeat (20) send_req(make_req(ACT_TICK, 1'b1, SPIN_STEPS, 1'b1, '1));
        send_req(make_req(ACT_MOVE, 1'b0, STEP_W'(2), 1'b0, RATE_W'(1000)));
        send_req(make_req(ACT_STOP, 1'b1, '0, 1'b0, '0));
        send_req(make_req(ACT_STOP, 1'b0, '0, 1'b0, '0));

        while (sent < TARGET_REQS) begin
            if (!drained && sent >= 500) begin
                drain_pending();
                drained = 1'b1;
            end
            if ($urandom_range(0, 9) < 7) begin
                // A well-formed move: sometimes free the axis first, load a short fast move, then send ticks.
                ax = 1'($urandom_range(0, 1));
                if ($urandom_range(0, 1))
                    send_req(make_req(ACT_STOP, ax, pick_steps(), 1'($urandom_range(0, 1)),
                                      pick_rate(1'b0)));
                send_req(make_req(ACT_MOVE, ax, STEP_W'($urandom_range(1, 3)),
                                  1'($urandom_range(0, 1)), pick_rate(1'b1)));
                n_ticks = $urandom_range(10, 60);
                for (k = 0; k < n_ticks; k++) begin
                    if ($urandom_range(0, 19) == 0)
                        send_req(make_req(ACT_SPEED, 1'($urandom_range(0, 1)), pick_steps(),
                                          1'($urandom_range(0, 1)), pick_rate(1'b1)));
                    else
                        send_req(make_req(ACT_TICK, 1'($urandom_range(0, 1)), pick_steps(),
                                          1'($urandom_range(0, 1)), pick_rate(1'b0)));
                end
            end else begin
                send_req(make_req(t_action'($urandom_range(0, 3)), 1'($urandom_range(0, 1)),
                                  pick_steps(), 1'($urandom_range(0, 1)), pick_rate(1'b0)));
            end
        end

        drain_pending();
        repeat (30) @(posedge clk);
        if (fails == 0)
            $display("dual_axis_step_pulse_generator_unit verification clean");
        else
            $display("dual_axis_step_pulse_generator_unit verification failed");
        $finish;
    end

endmodule
